>>> rtl/atcp_pkg.sv
// ----------------------------------------------------------------------------
// atcp_pkg: shared types and constants of the AT command token parser
// Reply codes, command word layout, reset values and the per-item result.
// ----------------------------------------------------------------------------
package atcp_pkg;

  localparam int NUM_CMDS   = 3;
  localparam int CMD_IDX_W  = 2;
  localparam int WORD_W     = 32;
  localparam int CHAR_W     = 8;
  localparam int REPLY_W    = 3;
  localparam int NAME_POS_W = 3;
  localparam int NAME_LEN   = 4;

  // Reply codes
  localparam logic [REPLY_W-1:0] RC_NONE  = 3'd0;
  localparam logic [REPLY_W-1:0] RC_OK    = 3'd1;
  localparam logic [REPLY_W-1:0] RC_ERROR = 3'd2;
  localparam logic [REPLY_W-1:0] RC_READ  = 3'd3;
  localparam logic [REPLY_W-1:0] RC_WRITE = 3'd4;

  // Configuration register indexes
  localparam logic [CMD_IDX_W-1:0] REG_CMD_WORD_0 = 2'd0;
  localparam logic [CMD_IDX_W-1:0] REG_CMD_WORD_1 = 2'd1;
  localparam logic [CMD_IDX_W-1:0] REG_CMD_WORD_2 = 2'd2;

  // Reset command names: "NAME", "PORT", "VERS"
  localparam logic [WORD_W-1:0] CMD_WORD_0_RST = 32'h4E41_4D45;
  localparam logic [WORD_W-1:0] CMD_WORD_1_RST = 32'h504F_5254;
  localparam logic [WORD_W-1:0] CMD_WORD_2_RST = 32'h5645_5253;

  // Characters
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  typedef logic [WORD_W-1:0] cmd_words_t [NUM_CMDS];

  typedef struct packed {
    logic [REPLY_W-1:0]   code;
    logic [CMD_IDX_W-1:0] idx;
  } parse_result_t;

endpackage

>>> rtl/at_command_token_parser.sv
// ----------------------------------------------------------------------------
// at_command_token_parser: AT command line recognizer
// One received character in, one reply out per transaction.
// ----------------------------------------------------------------------------
// Path: input register, then the reply register behind one pass of parser
//   logic; while the reply register is stalled the character waits in the
//   input register.
// Throughput: one character per cycle while out_ready stays high.
// Reset: synchronous active-low rst_n empties both registers, sets the parser
//   idle with all candidates alive and loads the default command names.
module at_command_token_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  // character input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [atcp_pkg::CHAR_W-1:0]    in_rx_char,
  // reply output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [atcp_pkg::REPLY_W-1:0]   out_reply_code,
  output logic [atcp_pkg::CMD_IDX_W-1:0] out_command_index,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [atcp_pkg::CMD_IDX_W-1:0] cfg_index,
  input  logic [atcp_pkg::WORD_W-1:0]    cfg_wdata
);
  import atcp_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  logic [CHAR_W-1:0] char_r;
  logic              out_vld_r, out_vld_nxt;
  parse_result_t     res_r;
  parse_result_t     step_res;
  cmd_words_t        words;
  logic              adv;

  // Configuration is always taken and lands at once; write it only while
  // no character or reply is in flight.
  assign cfg_ready = 1'b1;

  atcp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .words    (words)
  );

  // Advance the held character into the reply register when the reply
  // slot is empty or being drained this cycle.
  assign adv      = in_vld_r & (~out_vld_r | out_ready);
  // Take a new character whenever the input register empties this cycle.
  assign in_ready = ~in_vld_r | adv;

  atcp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_char (char_r),
    .words   (words),
    .result  (step_res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid & in_ready) in_vld_nxt = 1'b1;
    else if (adv)            in_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (adv)            out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: capture on transaction, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid & in_ready) char_r <= in_rx_char;
    if (adv)                 res_r  <= step_res;
  end

  assign out_valid         = out_vld_r;
  assign out_reply_code    = res_r.code;
  assign out_command_index = res_r.idx;

`ifndef NO_ASSERTIONS
  // Every parser step must show up as a pending reply next cycle.
  a_step_gives_reply: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("parser step produced no reply");

  // The command index is only meaningful with read or write replies.
  a_idx_only_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.code != RC_READ && res_r.code != RC_WRITE)
      |-> res_r.idx == '0)
    else $error("command index set without read or write reply");

  // Replies stay within the defined codes.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.code == RC_NONE || res_r.code == RC_OK ||
                   res_r.code == RC_ERROR || res_r.code == RC_READ ||
                   res_r.code == RC_WRITE))
    else $error("undefined reply code");

  // A held character that cannot advance must block new input.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && !out_ready) |=> $stable(char_r))
    else $error("held character overwritten while stalled");
`endif

endmodule

>>> rtl/atcp_cfg_regs.sv
// ----------------------------------------------------------------------------
// atcp_cfg_regs: command word register file
// Three 32-bit command names, written through the configuration channel.
// ----------------------------------------------------------------------------
module atcp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [atcp_pkg::CMD_IDX_W-1:0] wr_index,
  input  logic [atcp_pkg::WORD_W-1:0]    wr_data,
  output atcp_pkg::cmd_words_t           words
);
  import atcp_pkg::*;

  cmd_words_t words_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r[0] <= CMD_WORD_0_RST;
      words_r[1] <= CMD_WORD_1_RST;
      words_r[2] <= CMD_WORD_2_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CMD_WORD_0: words_r[0] <= wr_data;
        REG_CMD_WORD_1: words_r[1] <= wr_data;
        REG_CMD_WORD_2: words_r[2] <= wr_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign words = words_r;

endmodule

>>> rtl/atcp_parser.sv
// ----------------------------------------------------------------------------
// atcp_parser: line parser state and per-character step logic
// Holds phase, name position and candidate mask; advances on each step.
// ----------------------------------------------------------------------------
module atcp_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [atcp_pkg::CHAR_W-1:0] rx_char,
  input  atcp_pkg::cmd_words_t        words,
  output atcp_pkg::parse_result_t     result
);
  import atcp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_GOT_A  = 3'd1,
    PH_GOT_AT = 3'd2,
    PH_NAME   = 3'd3,
    PH_RW     = 3'd4
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [NAME_POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [NUM_CMDS-1:0]   alive_r, alive_nxt, alive_and, hit;
  parse_result_t         res;

  // Name character at a position; positions past the word read as zero
  function automatic logic [CHAR_W-1:0] name_char(input logic [WORD_W-1:0] word,
                                                   input logic [NAME_POS_W-1:0] pos);
    logic [CHAR_W-1:0] ch;
    case (pos[1:0])
      2'd0:    ch = word[31:24];
      2'd1:    ch = word[23:16];
      2'd2:    ch = word[15:8];
      default: ch = word[7:0];
    endcase
    return pos[2] ? '0 : ch;
  endfunction

  function automatic logic [CMD_IDX_W-1:0] lowest_alive(input logic [NUM_CMDS-1:0] m);
    logic [CMD_IDX_W-1:0] i;
    if (m[0])      i = 2'd0;
    else if (m[1]) i = 2'd1;
    else if (m[2]) i = 2'd2;
    else           i = 2'd0;
    return i;
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_CMDS; k++) begin
      hit[k] = (name_char(words[k], pos_r) == rx_char);
    end
  end

  assign alive_and = alive_r & hit;
  assign pos_inc   = pos_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    res.code  = RC_NONE;
    res.idx   = '0;
    if (rx_char != CH_LF) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (rx_char == CH_A) phase_nxt = PH_GOT_A;
        end
        PH_GOT_A: begin
          if (rx_char == CH_T) begin
            phase_nxt = PH_GOT_AT;
          end else begin
            phase_nxt = PH_IDLE;
            res.code  = RC_ERROR;
          end
        end
        PH_GOT_AT: begin
          if (rx_char == CH_PLUS) begin
            phase_nxt = PH_NAME;
            pos_nxt   = '0;
            alive_nxt = '1;
          end else if (rx_char == CH_CR) begin
            phase_nxt = PH_IDLE;
            res.code  = RC_OK;
          end
        end
        PH_NAME: begin
          alive_nxt = alive_and;
          if (alive_and == '0) begin
            phase_nxt = PH_IDLE;
            res.code  = RC_ERROR;
          end else begin
            pos_nxt = pos_inc;
            if ({1'b0, pos_inc} >= (NAME_POS_W+1)'(NAME_LEN) || pos_inc == '0) begin
              phase_nxt = PH_RW;
            end
          end
        end
        PH_RW: begin
          if (rx_char == CH_QUERY) begin
            res.code = RC_READ;
            res.idx  = lowest_alive(alive_r);
          end else if (rx_char == CH_EQUAL) begin
            res.code = RC_WRITE;
            res.idx  = lowest_alive(alive_r);
          end
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      alive_r <= '1;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
    end
  end

  assign result = res;

endmodule

>>> tb/sv/at_command_token_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// at_command_token_parser_tb: self-checking bench for the AT line recognizer
// Streams characters into the parser, predicts every reply from a local copy
// of the parse state and the command words, and compares replies in order.
// ----------------------------------------------------------------------------
module at_command_token_parser_tb;
  import atcp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_CHARS  = 120;
  localparam int NUM_SETTINGS = 6;
  localparam int HOLD_AT      = 330;  // reply count that starts the long hold-off
  localparam int HOLD_CYCLES  = 250;
  localparam int REPORT_MAX   = 10;

  // Index 3 is decoded by nothing; writes to it must leave the words alone
  localparam logic [CMD_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_GOT_A  = 3'd1,
    PH_GOT_AT = 3'd2,
    PH_NAME   = 3'd3,
    PH_RW     = 3'd4
  } parse_phase_t;

  // --------------------------------------------------------------------------
  // Reply predictor: mirrors the parse state, queues one reply per character
  // --------------------------------------------------------------------------
  class at_reply_predictor;
    logic [WORD_W-1:0]     cmd_word [NUM_CMDS];
    parse_phase_t          phase;
    logic [NAME_POS_W-1:0] name_pos;
    logic [NUM_CMDS-1:0]   alive;
    parse_result_t         expected_replies [$];
    int                    bad_replies;

    function new();
      cmd_word[0] = CMD_WORD_0_RST;
      cmd_word[1] = CMD_WORD_1_RST;
      cmd_word[2] = CMD_WORD_2_RST;
      phase       = PH_IDLE;
      name_pos    = '0;
      alive       = '1;
      bad_replies = 0;
    endfunction

    function void write_word(logic [CMD_IDX_W-1:0] index, logic [WORD_W-1:0] value);
      case (index)
        REG_CMD_WORD_0: cmd_word[0] = value;
        REG_CMD_WORD_1: cmd_word[1] = value;
        REG_CMD_WORD_2: cmd_word[2] = value;
        default: ;
      endcase
    endfunction

    // Positions past the word compare against a zero byte
    function logic [CHAR_W-1:0] name_char(int k, logic [NAME_POS_W-1:0] pos);
      int p;
      p = pos;
      if (p >= NAME_LEN) return '0;
      return cmd_word[k][CHAR_W*(NAME_LEN-1-p) +: CHAR_W];
    endfunction

    function void take_char(logic [CHAR_W-1:0] c);
      parse_result_t       r;
      logic [NUM_CMDS-1:0] hit;
      r.code = RC_NONE;
      r.idx  = '0;
      if (c != CH_LF) begin
        case (phase)
          PH_IDLE: if (c == CH_A) phase = PH_GOT_A;
          PH_GOT_A: begin
            if (c == CH_T) begin
              phase = PH_GOT_AT;
            end else begin
              phase  = PH_IDLE;
              r.code = RC_ERROR;
            end
          end
          PH_GOT_AT: begin
            if (c == CH_PLUS) begin
              phase    = PH_NAME;
              name_pos = '0;
              alive    = '1;
            end else if (c == CH_CR) begin
              phase  = PH_IDLE;
              r.code = RC_OK;
            end
          end
          PH_NAME: begin
            for (int k = 0; k < NUM_CMDS; k++) hit[k] = (name_char(k, name_pos) == c);
            alive = alive & hit;
            if (alive == '0) begin
              phase  = PH_IDLE;
              r.code = RC_ERROR;
            end else begin
              name_pos = name_pos + 1'b1;
              if (name_pos >= NAME_LEN || name_pos == '0) phase = PH_RW;
            end
          end
          PH_RW: begin
            if (c == CH_QUERY || c == CH_EQUAL) begin
              r.code = (c == CH_QUERY) ? RC_READ : RC_WRITE;
              r.idx  = alive[0] ? 2'd0 : alive[1] ? 2'd1 : alive[2] ? 2'd2 : 2'd0;
            end
            phase = PH_IDLE;
          end
          default: phase = PH_IDLE;
        endcase
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [REPLY_W-1:0] code, logic [CMD_IDX_W-1:0] idx);
      parse_result_t want;
      if (expected_replies.size() == 0) begin
        bad_replies++;
        if (bad_replies <= REPORT_MAX)
          $display("unexpected reply: code %0d index %0d", code, idx);
        return;
      end
      want = expected_replies.pop_front();
      if (code !== want.code || idx !== want.idx) begin
        bad_replies++;
        if (bad_replies <= REPORT_MAX)
          $display("reply mismatch: expected code %0d index %0d, got code %0d index %0d",
                   want.code, want.idx, code, idx);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CHAR_W-1:0]    in_rx_char;
  logic                 out_valid;
  logic                 out_ready;
  logic [REPLY_W-1:0]   out_reply_code;
  logic [CMD_IDX_W-1:0] out_command_index;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CMD_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  at_reply_predictor replies;
  int                chars_sent  = 0;
  int unsigned       cycle_count = 0;
  bit                sender_calm = 1'b0;

  at_command_token_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_char        (in_rx_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_code    (out_reply_code),
    .out_command_index (out_command_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a missing reply or a stuck handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Reply side: accept and check replies, stall at random. After HOLD_AT
  // replies, hold off once for a long stretch so the parser backs up and
  // drops in_ready while characters keep coming.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left = 0;
    int hold_left  = 0;
    int seen       = 0;
    int beat       = 0;
    bit hold_done  = 1'b0;
    bit calm;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (rst_n && out_valid && out_ready) begin
        replies.check_reply(out_reply_code, out_command_index);
        seen++;
      end
      if (seen >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      // in one beat window out of three the receiver draws no new random stalls
      calm = ((beat / 256) % 3) == 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Character side
  // --------------------------------------------------------------------------

  // Offer one character, hold it until the transaction completes, note it.
  // Drop valid only when a gap is taken, so valid is never lowered and
  // raised in the same step.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_char <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies.take_char(c);
    if (c != CH_LF) chars_sent++;
  endtask

  // Line feeds are ignored in every phase; sprinkle them in
  task automatic send_item(input logic [CHAR_W-1:0] c);
    if ($urandom_range(0, 19) == 0) send_char(CH_LF);
    send_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // One random line: mostly well-formed commands with random content,
  // the rest bare AT lines, broken prefixes and noise
  task automatic send_random_line();
    int                kind;
    int                k;
    int                term;
    logic [CHAR_W-1:0] ch;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      send_item(CH_A);
      send_item(CH_T);
      send_item(CH_PLUS);
      k = $urandom_range(0, NUM_CMDS - 1);
      for (int p = 0; p < NAME_LEN; p++) begin
        ch = replies.name_char(k, NAME_POS_W'(p));
        // corrupt a name character now and then to kill candidates
        if ($urandom_range(0, 11) == 0) ch = CHAR_W'($urandom);
        send_item(ch);
      end
      term = $urandom_range(0, 99);
      if (term < 45) send_item(CH_QUERY);
      else if (term < 90) send_item(CH_EQUAL);
      else send_item(CHAR_W'($urandom));
    end else if (kind < 72) begin
      send_item(CH_A);
      send_item(CH_T);
      // junk after AT is skipped while waiting for the carriage return
      if ($urandom_range(0, 2) == 0) send_item(CHAR_W'($urandom));
      send_item(CH_CR);
    end else if (kind < 82) begin
      send_item(CH_A);
      send_item(CHAR_W'($urandom));
    end else begin
      send_item(CHAR_W'($urandom));
    end
  endtask

  // Drop valid and wait until every queued reply has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load a set of command words; the unused index is written too
  task automatic program_words(input int setting);
    logic [WORD_W-1:0]    w [NUM_CMDS];
    logic [WORD_W-1:0]    base;
    logic [WORD_W-1:0]    data;
    logic [CMD_IDX_W-1:0] order [4];
    order = '{REG_CMD_WORD_0, REG_UNUSED, REG_CMD_WORD_1, REG_CMD_WORD_2};
    base  = $urandom;
    case (setting)
      0: begin
        w[0] = '0;
        w[1] = '1;
        w[2] = '0;
      end
      1: begin
        w[0] = '1;
        w[1] = '1;
        w[2] = '1;
      end
      2: begin
        // shared prefixes so candidates fall away one by one
        w[0] = base;
        w[1] = {base[WORD_W-1:CHAR_W], CHAR_W'($urandom)};
        w[2] = {base[WORD_W-1:2*CHAR_W], (2*CHAR_W)'($urandom)};
      end
      3: begin
        w[0] = $urandom;
        w[1] = $urandom;
        w[2] = $urandom;
      end
      4: begin
        w[0] = base;
        w[1] = base;
        w[2] = base;
      end
      default: begin
        w[0] = CMD_WORD_0_RST;
        w[1] = CMD_WORD_1_RST;
        w[2] = CMD_WORD_2_RST;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      if (order[i] == REG_UNUSED) data = $urandom;
      else data = w[order[i]];
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      replies.write_word(order[i], data);
    end
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int target;
    replies    = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_char <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines against the default names
    send_text("AT+NAME?");     // read of the first command
    send_text("AT+VERS=");     // write of the last command
    send_text("AT+PX");        // candidates die mid-name
    send_text("AZ");           // no T after A
    send_text("A\nTq\r");      // line feed skipped, junk after AT skipped, OK

    // Random phases, each under its own set of command words. Reprogram
    // only once the parser has nothing left in flight.
    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      wait_drained();
      program_words(setting);
      sender_calm = (setting == 2);
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) send_random_line();
    end

    wait_drained();
    if (replies.bad_replies == 0 && replies.expected_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
